[sv/assert_macros.svh]
// Assertion macros shared by the chroma key RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define CKP_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a consequent holds whenever an antecedent holds.
`define CKP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CKP_ASSERT(lbl, clk, rst_n, cond, msg)
`define CKP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/ckp_pkg.sv]
// Types, constants and helpers of the chroma key block.
`default_nettype none
package ckp_pkg;

  localparam int PaletteSize = 10;
  localparam int SlotW       = (PaletteSize > 1) ? $clog2(PaletteSize) : 1;
  localparam int CfgIdxW     = 2;

  localparam logic [7:0] DrawTol        = 8'd5;
  localparam logic [7:0] AlphaOpaque    = 8'd255;
  localparam logic [7:0] AlphaClear     = 8'd0;
  localparam logic [7:0] ThresholdReset = 8'd30;
  localparam logic [7:0] EraseGreenBase = 8'd100;
  localparam logic [7:0] EraseGreenStep = 8'd5;

  localparam logic [CfgIdxW-1:0] CfgKeyThreshold = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPickToErase  = CfgIdxW'(1);

  typedef enum logic {
    CmdKey  = 1'b0,
    CmdPick = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Item as it travels down the cell chain.
  typedef struct packed {
    cmd_e             cmd;
    logic             to_erase;
    logic [SlotW-1:0] slot;
    rgb_t             pix;
    logic             erase_hit;
    logic             draw_hit;
  } item_t;

  // Reset green level of erase entry idx.
  function automatic logic [7:0] erase_reset_green(logic [SlotW-1:0] idx);
    logic [15:0] prod;
    prod = 16'(idx) * 16'(EraseGreenStep);
    return EraseGreenBase + prod[7:0];
  endfunction

endpackage
`default_nettype wire

[sv/ckp_cell.sv]
// One chain cell: holds an erase and a draw entry and matches passing pixels.
`default_nettype none
`include "assert_macros.svh"
module ckp_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic [7:0]                thr_i,
  input  wire logic [ckp_pkg::SlotW-1:0] cell_idx_i,
  input  wire logic                      valid_i,
  input  wire ckp_pkg::item_t            item_i,
  output logic                           valid_o,
  output ckp_pkg::item_t                 item_o
);

  function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic near(ckp_pkg::rgb_t p, ckp_pkg::rgb_t q, logic [7:0] tol);
    return (abs_diff(p.red, q.red) < tol) &&
           (abs_diff(p.green, q.green) < tol) &&
           (abs_diff(p.blue, q.blue) < tol);
  endfunction

  ckp_pkg::rgb_t  erase_q, draw_q;
  logic           valid_q;
  ckp_pkg::item_t item_q, item_d;
  logic           pick_here, erase_we, draw_we;

  // Decode a pick aimed at this cell
  assign pick_here = adv_i && valid_i && (item_i.cmd == ckp_pkg::CmdPick) &&
                     (item_i.slot == cell_idx_i);
  assign erase_we  = pick_here && item_i.to_erase;
  assign draw_we   = pick_here && !item_i.to_erase;

  // Accumulate palette matches against the entries held here
  always_comb begin
    item_d = item_i;
    item_d.erase_hit = item_i.erase_hit | near(item_i.pix, erase_q, thr_i);
    item_d.draw_hit  = item_i.draw_hit  | near(item_i.pix, draw_q, ckp_pkg::DrawTol);
  end

  // Store picked colors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q <= '{red: 8'd0, green: ckp_pkg::erase_reset_green(cell_idx_i), blue: 8'd0};
      draw_q  <= '0;
    end else begin
      if (erase_we) erase_q <= item_i.pix;
      if (draw_we)  draw_q  <= item_i.pix;
    end
  end

  // Hand the item to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  `CKP_ASSERT_IMPLY(a_erase_hold, clk_i, rst_ni, !$past(erase_we), erase_q == $past(erase_q),
                    "erase entry changed without a pick transfer")
  `CKP_ASSERT_IMPLY(a_draw_hold, clk_i, rst_ni, !$past(draw_we), draw_q == $past(draw_q),
                    "draw entry changed without a pick transfer")

endmodule
`default_nettype wire

[sv/ckp_out.sv]
// Output stage: green dominance test, alpha decision and result register.
`default_nettype none
`include "assert_macros.svh"
module ckp_out (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     thr_i,
  input  wire logic           valid_i,
  input  wire ckp_pkg::item_t item_i,
  input  wire logic           out_ready_i,
  output logic                adv_o,
  output logic                out_valid_o,
  output ckp_pkg::pix_out_t   out_data_o
);

  logic              out_valid_q;
  ckp_pkg::pix_out_t out_q, out_d;
  logic              green_dom;
  logic [7:0]        g_minus_r;

  // Advance the chain whenever the result register is free or being taken
  assign adv_o = !out_valid_q || out_ready_i;

  // Decide alpha
  always_comb begin
    g_minus_r = item_i.pix.green - item_i.pix.red;
    green_dom = (item_i.pix.green > item_i.pix.red) &&
                (item_i.pix.green > item_i.pix.blue) && (g_minus_r > thr_i);
    out_d.out_red   = item_i.pix.red;
    out_d.out_green = item_i.pix.green;
    out_d.out_blue  = item_i.pix.blue;
    if (item_i.draw_hit) begin
      out_d.out_alpha = ckp_pkg::AlphaOpaque;
    end else if (green_dom || item_i.erase_hit) begin
      out_d.out_alpha = ckp_pkg::AlphaClear;
    end else begin
      out_d.out_alpha = ckp_pkg::AlphaOpaque;
    end
  end

  // Load key results, drop picks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= valid_i && (item_i.cmd == ckp_pkg::CmdKey);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CKP_ASSERT_IMPLY(a_alpha_code, clk_i, rst_ni, out_valid_q,
                    out_q.out_alpha == ckp_pkg::AlphaOpaque ||
                    out_q.out_alpha == ckp_pkg::AlphaClear,
                    "alpha is neither clear nor opaque")

endmodule
`default_nettype wire

[sv/chroma_key_color_palette_top.sv]
// Top level of the chroma key block with erase and draw palettes.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    in_data_i  (cmd, red, green, blue)
//   out      output     out_valid_o / out_ready_i  out_data_o (RGB and alpha)
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item enters per cycle while the chain advances; a pixel result is registered in
// each cell of the chain (one palette entry pair per cell) and then in the result register.
// Picks travel the chain like pixels and write the matching cell; they give no result.
// The whole chain holds while the result register is full and not taken.
// Reset loads the palette reset colors directly; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module chroma_key_color_palette_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ckp_pkg::pix_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ckp_pkg::pix_out_t                out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ckp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i
);

  localparam int N = ckp_pkg::PaletteSize;

  logic [7:0]                  thr_q;
  logic                        to_erase_q;
  logic [ckp_pkg::SlotW-1:0]   erase_slot_q, draw_slot_q;
  logic                        adv, in_xfer, pick_xfer;
  logic                        valid_w [0:N];
  ckp_pkg::item_t              item_w  [0:N];

  function automatic logic [ckp_pkg::SlotW-1:0] next_slot(logic [ckp_pkg::SlotW-1:0] s);
    return (s == ckp_pkg::SlotW'(N - 1)) ? '0 : s + 1'b1;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = adv;
  assign in_xfer     = in_valid_i && adv;
  assign pick_xfer   = in_xfer && (in_data_i.cmd == ckp_pkg::CmdPick);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ckp_pkg::ThresholdReset;
      to_erase_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ckp_pkg::CfgKeyThreshold) thr_q <= cfg_data_i;
      if (cfg_index_i == ckp_pkg::CfgPickToErase)  to_erase_q <= cfg_data_i[0];
    end
  end

  // Advance the slot pointer of the selected ring on each pick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_slot_q <= '0;
      draw_slot_q  <= '0;
    end else if (pick_xfer) begin
      if (to_erase_q) erase_slot_q <= next_slot(erase_slot_q);
      else            draw_slot_q  <= next_slot(draw_slot_q);
    end
  end

  // Build the chain entry item
  assign valid_w[0] = in_valid_i;
  assign item_w[0]  = '{cmd:       in_data_i.cmd,
                        to_erase:  to_erase_q,
                        slot:      to_erase_q ? erase_slot_q : draw_slot_q,
                        pix:       '{red:   in_data_i.red,
                                     green: in_data_i.green,
                                     blue:  in_data_i.blue},
                        erase_hit: 1'b0,
                        draw_hit:  1'b0};

  // Chain of palette cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    ckp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .thr_i      (thr_q),
      .cell_idx_i (ckp_pkg::SlotW'(k)),
      .valid_i    (valid_w[k]),
      .item_i     (item_w[k]),
      .valid_o    (valid_w[k+1]),
      .item_o     (item_w[k+1])
    );
  end

  ckp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .valid_i     (valid_w[N]),
    .item_i      (item_w[N]),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `CKP_ASSERT(a_erase_slot_range, clk_i, rst_ni, erase_slot_q < ckp_pkg::SlotW'(N - 1) ||
              erase_slot_q == ckp_pkg::SlotW'(N - 1), "erase slot beyond palette")
  `CKP_ASSERT(a_draw_slot_range, clk_i, rst_ni, draw_slot_q < ckp_pkg::SlotW'(N - 1) ||
              draw_slot_q == ckp_pkg::SlotW'(N - 1), "draw slot beyond palette")

endmodule
`default_nettype wire
